>>> rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_ADD   = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_DF  = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  typedef struct packed {
    logic       load_req;
    logic       set_st;
    logic [1:0] st_code;
    logic       a_start;
    logic       a_take;
    logic       a_inc;
    logic       a_pop;
    logic       a_split;
    logic       a_finish;
    logic       f_read_mark;
    logic       f_clear;
    logic       f_bud;
    logic       u_start;
    logic       u_read;
    logic       u_hit;
    logic       u_step;
    logic       f_push;
    logic       r_start;
    logic       r_step;
    logic       clr_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       ord_bad;
    logic       page_bad;
    logic       head_valid;
    logic       o_at_top;
    logic       o_above_ord;
    logic       mark_rd;
    logic       bud_ok;
    logic       cur_end;
    logic       cur_hit;
    logic       pg_below_top;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/core/bpa_dp.sv
module bpa_dp #(
  parameter int PAGE_COUNT = 65536,
  parameter int TOP_ORDER  = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpa_pkg::cmd_t     cmd,
  output bpa_pkg::sts_t     sts,
  input  logic [1:0]        in_func,
  input  logic [3:0]        in_order,
  input  logic [15:0]       in_block_page,
  input  logic [16:0]       in_region_pages,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [15:0]       out_result_page,
  output logic [16:0]       out_free_pages,
  output logic [16:0]       out_total_pages
);

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int LW = PW + 1;
  localparam int AW = (PW > 17) ? PW + 1 : 18;
  localparam int OW = $clog2(TOP_ORDER + 1);
  localparam int NH = TOP_ORDER + 1;
  localparam logic [LW-1:0] NONE = '1;
  localparam logic [LW-1:0] PC_L = LW'(PAGE_COUNT);
  localparam logic [AW-1:0] PC_A = AW'(PAGE_COUNT);
  localparam logic [3:0]    TOP4 = 4'(TOP_ORDER);

  function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? 17'h1FFFF : s[16:0];
  endfunction

  function automatic logic [16:0] floor_sub(input logic [16:0] a, input logic [16:0] b);
    return (b > a) ? 17'd0 : a - b;
  endfunction

  logic [1:0]    func_r;
  logic [3:0]    ord_r;
  logic [15:0]   page_r;
  logic [16:0]   rlen_r;
  logic [3:0]    o_r;
  logic [AW-1:0] pg_r, top_r;
  logic [LW-1:0] blk_r, prev_r, cur_r, steps_r, clr_r;
  logic [LW-1:0] heads_r [NH];
  logic [16:0]   free_r, total_r;
  logic [1:0]    st_r;
  logic [15:0]   res_r;
  logic          out_valid_r;
  logic [1:0]    out_st_r;
  logic [15:0]   out_res_r;
  logic [16:0]   out_free_r, out_total_r;

  logic [LW-1:0] link_mem [PAGE_COUNT];
  logic          mark_mem [PAGE_COUNT];
  logic [LW-1:0] link_rd_r;
  logic          mark_rd_r;

  logic [OW-1:0] oi, om1, r_oi;
  logic [LW-1:0] head_cur;
  logic [AW-1:0] page_a, bud, split_pg, r_size, nsize;
  logic [3:0]    r_ord;
  logic          r_go;
  logic [16:0]   ord_size;

  logic          lw_en;
  logic [PW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic          mw_en;
  logic [PW-1:0] mw_addr;
  logic          mw_data;
  logic [PW-1:0] mr_addr, lr_addr;

  assign oi       = o_r[OW-1:0];
  assign om1      = OW'(o_r - 4'd1);
  assign head_cur = heads_r[oi];
  assign page_a   = AW'(page_r);
  assign bud      = pg_r ^ (AW'(1) << o_r);
  assign split_pg = AW'(blk_r) + (AW'(1) << (o_r - 4'd1));
  assign ord_size = 17'(1) << ord_r;

  // largest aligned block that fits between pg_r and top_r
  always_comb begin
    r_ord = 4'd0;
    r_go  = 1'b1;
    nsize = '0;
    for (int k = 1; k <= TOP_ORDER; k++) begin
      nsize = AW'(1) << k;
      if (r_go && ((pg_r & (nsize - AW'(1))) == '0) && (pg_r + nsize <= top_r))
        r_ord = 4'(k);
      else
        r_go = 1'b0;
    end
  end
  assign r_oi   = r_ord[OW-1:0];
  assign r_size = AW'(1) << r_ord;

  always_comb begin
    sts.func         = func_r;
    sts.ord_bad      = ord_r > TOP4;
    sts.page_bad     = page_a >= PC_A;
    sts.head_valid   = head_cur < PC_L;
    sts.o_at_top     = o_r == TOP4;
    sts.o_above_ord  = o_r > ord_r;
    sts.mark_rd      = mark_rd_r;
    sts.bud_ok       = bud < PC_A;
    sts.cur_end      = !(cur_r < PC_L) || (steps_r == PC_L);
    sts.cur_hit      = AW'(cur_r) == bud;
    sts.pg_below_top = pg_r < top_r;
    sts.clr_last     = clr_r == PC_L - LW'(1);
    sts.out_free     = !out_valid_r || out_ready;
  end

  // link memory write port
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = pg_r[PW-1:0];
    lw_data = head_cur;
    if (cmd.a_split && split_pg < PC_A) begin
      lw_en   = 1'b1;
      lw_addr = split_pg[PW-1:0];
      lw_data = heads_r[om1];
    end else if (cmd.f_push && pg_r < PC_A) begin
      lw_en = 1'b1;
    end else if (cmd.r_step) begin
      lw_en   = 1'b1;
      lw_data = heads_r[r_oi];
    end else if (cmd.u_hit && prev_r != NONE) begin
      lw_en   = 1'b1;
      lw_addr = prev_r[PW-1:0];
      lw_data = link_rd_r;
    end
  end

  always_comb begin
    mw_en   = 1'b0;
    mw_addr = clr_r[PW-1:0];
    mw_data = 1'b0;
    if (cmd.clr_step) begin
      mw_en = 1'b1;
    end else if (cmd.f_clear) begin
      mw_en   = 1'b1;
      mw_addr = page_a[PW-1:0];
    end else if (cmd.a_finish) begin
      mw_en   = 1'b1;
      mw_addr = blk_r[PW-1:0];
      mw_data = 1'b1;
    end
  end

  assign mr_addr = cmd.f_read_mark ? page_a[PW-1:0] : bud[PW-1:0];
  assign lr_addr = cmd.a_take ? head_cur[PW-1:0] : cur_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (lw_en)
      link_mem[lw_addr] <= lw_data;
    link_rd_r <= link_mem[lr_addr];
  end

  always_ff @(posedge clk) begin
    if (mw_en)
      mark_mem[mw_addr] <= mw_data;
    mark_rd_r <= mark_mem[mr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NH; i++)
        heads_r[i] <= NONE;
    end else if (cmd.a_pop || (cmd.u_hit && prev_r == NONE)) begin
      heads_r[oi] <= link_rd_r;
    end else if (cmd.a_split && split_pg < PC_A) begin
      heads_r[om1] <= split_pg[LW-1:0];
    end else if (cmd.f_push && pg_r < PC_A) begin
      heads_r[oi] <= pg_r[LW-1:0];
    end else if (cmd.r_step) begin
      heads_r[r_oi] <= pg_r[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      free_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step)
        clr_r <= clr_r + LW'(1);
      if (cmd.a_finish)
        free_r <= floor_sub(free_r, ord_size);
      else if (cmd.f_clear)
        free_r <= sat_add(free_r, ord_size);
      else if (cmd.r_step)
        free_r <= sat_add(free_r, 17'(r_size));
      if (cmd.r_step)
        total_r <= sat_add(total_r, 17'(r_size));
      if (cmd.out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r <= in_func;
      ord_r  <= in_order;
      page_r <= in_block_page;
      rlen_r <= in_region_pages;
      st_r   <= bpa_pkg::ST_OK;
      res_r  <= '0;
    end
    if (cmd.set_st)
      st_r <= cmd.st_code;
    if (cmd.a_start || cmd.f_clear)
      o_r <= ord_r;
    else if (cmd.a_inc || cmd.u_hit)
      o_r <= o_r + 4'd1;
    else if (cmd.a_split)
      o_r <= o_r - 4'd1;
    if (cmd.a_take)
      blk_r <= head_cur;
    if (cmd.a_finish)
      res_r <= 16'(AW'(blk_r));
    if (cmd.f_clear)
      pg_r <= page_a;
    else if (cmd.r_start)
      pg_r <= page_a;
    else if (cmd.r_step)
      pg_r <= pg_r + r_size;
    else if (cmd.u_hit && bud < pg_r)
      pg_r <= bud;
    if (cmd.r_start)
      top_r <= (page_a + AW'(rlen_r) > PC_A) ? PC_A : page_a + AW'(rlen_r);
    if (cmd.u_start) begin
      cur_r   <= head_cur;
      prev_r  <= NONE;
      steps_r <= '0;
    end else if (cmd.u_step) begin
      prev_r  <= cur_r;
      cur_r   <= link_rd_r;
      steps_r <= steps_r + LW'(1);
    end
    if (cmd.out_load) begin
      out_st_r    <= st_r;
      out_res_r   <= res_r;
      out_free_r  <= free_r;
      out_total_r <= total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_result_page = out_res_r;
  assign out_free_pages  = out_free_r;
  assign out_total_pages = out_total_r;

  a_take_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.a_take |-> o_r <= TOP4) else $error("search order beyond top");
  a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.a_finish |-> o_r == ord_r) else $error("split ended at wrong order");
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.u_hit |-> cur_r < PC_L) else $error("unlink on empty link");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");

endmodule

>>> rtl/core/bpa_ctrl.sv
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DEC     = 4'd2;
  localparam logic [3:0] S_A_SRCH  = 4'd3;
  localparam logic [3:0] S_A_POP   = 4'd4;
  localparam logic [3:0] S_A_SPLIT = 4'd5;
  localparam logic [3:0] S_F_MARK  = 4'd6;
  localparam logic [3:0] S_F_BUD   = 4'd7;
  localparam logic [3:0] S_F_BMARK = 4'd8;
  localparam logic [3:0] S_U_CHK   = 4'd9;
  localparam logic [3:0] S_U_NEXT  = 4'd10;
  localparam logic [3:0] S_F_PUSH  = 4'd11;
  localparam logic [3:0] S_R_LOOP  = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last)
          state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.func)
          bpa_pkg::FN_ALLOC: begin
            if (sts.ord_bad) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bpa_pkg::ST_BAD;
              state_nxt   = S_FIN;
            end else begin
              cmd.a_start = 1'b1;
              state_nxt   = S_A_SRCH;
            end
          end
          bpa_pkg::FN_FREE: begin
            if (sts.ord_bad || sts.page_bad) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = bpa_pkg::ST_BAD;
              state_nxt   = S_FIN;
            end else begin
              cmd.f_read_mark = 1'b1;
              state_nxt       = S_F_MARK;
            end
          end
          bpa_pkg::FN_ADD: begin
            cmd.r_start = 1'b1;
            state_nxt   = S_R_LOOP;
          end
          default: begin
            cmd.set_st  = 1'b1;
            cmd.st_code = bpa_pkg::ST_BAD;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_A_SRCH: begin
        if (sts.head_valid) begin
          cmd.a_take = 1'b1;
          state_nxt  = S_A_POP;
        end else if (sts.o_at_top) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = bpa_pkg::ST_OOM;
          state_nxt   = S_FIN;
        end else begin
          cmd.a_inc = 1'b1;
        end
      end
      S_A_POP: begin
        cmd.a_pop = 1'b1;
        state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (sts.o_above_ord) begin
          cmd.a_split = 1'b1;
        end else begin
          cmd.a_finish = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_F_MARK: begin
        if (!sts.mark_rd) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = bpa_pkg::ST_DF;
          state_nxt   = S_FIN;
        end else begin
          cmd.f_clear = 1'b1;
          state_nxt   = S_F_BUD;
        end
      end
      S_F_BUD: begin
        if (sts.o_at_top || !sts.bud_ok) begin
          state_nxt = S_F_PUSH;
        end else begin
          cmd.f_bud = 1'b1;
          state_nxt = S_F_BMARK;
        end
      end
      S_F_BMARK: begin
        if (sts.mark_rd) begin
          state_nxt = S_F_PUSH;
        end else begin
          cmd.u_start = 1'b1;
          state_nxt   = S_U_CHK;
        end
      end
      S_U_CHK: begin
        if (sts.cur_end) begin
          state_nxt = S_F_PUSH;
        end else begin
          cmd.u_read = 1'b1;
          state_nxt  = S_U_NEXT;
        end
      end
      S_U_NEXT: begin
        if (sts.cur_hit) begin
          cmd.u_hit = 1'b1;
          state_nxt = S_F_BUD;
        end else begin
          cmd.u_step = 1'b1;
          state_nxt  = S_U_CHK;
        end
      end
      S_F_PUSH: begin
        cmd.f_push = 1'b1;
        state_nxt  = S_FIN;
      end
      S_R_LOOP: begin
        if (sts.pg_below_top)
          cmd.r_step = 1'b1;
        else
          state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_CLEAR;
    else
      state_r <= state_nxt;
  end

endmodule

>>> rtl/core/buddy_page_allocator_unit.sv
// Buddy page allocator: one request in (in_func/in_order/in_block_page/
// in_region_pages) gives one result out (status, page, free and total counts).
// Both channels are valid/ready; one request is worked on at a time.
// After reset the allocation-mark memory is swept clear, one page per cycle,
// and in_ready stays low until the sweep is done.
// Bad arguments and double frees end the request early. An allocate searches
// upward through the orders for a non-empty list, then splits the block down
// one order at a time; a free checks each buddy and walks its free list to
// unlink it before merging; adding a region carves it into aligned blocks.
// A free walks the list through the link memory, one registered read per
// entry. The result sits in an output register: the next request can be
// accepted while it waits, and a stalled receiver only holds the block once
// the following result is ready to be written.
module buddy_page_allocator_unit #(
  parameter int PAGE_COUNT = 65536,
  parameter int TOP_ORDER  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_order,
  input  logic [15:0] in_block_page,
  input  logic [16:0] in_region_pages,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_page,
  output logic [16:0] out_free_pages,
  output logic [16:0] out_total_pages
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_dp #(
    .PAGE_COUNT (PAGE_COUNT),
    .TOP_ORDER  (TOP_ORDER)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_order        (in_order),
    .in_block_page   (in_block_page),
    .in_region_pages (in_region_pages),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_page (out_result_page),
    .out_free_pages  (out_free_pages),
    .out_total_pages (out_total_pages)
  );

endmodule
